[rtl/core/ecfr_pkg.sv]
// Package for the escaped CRC-16 frame receiver: codes, register indexes,
// phase encoding and the structs passed between the receiver modules.
// No dependencies.
package ecfr_pkg;

    localparam int MAX_FRAME     = 1024;
    localparam int LEN_W         = 11;
    localparam int LEN_FIELD_MAX = (1 << LEN_W) - 1;
    localparam int LEN_LIMIT_I   = (MAX_FRAME > LEN_FIELD_MAX) ? LEN_FIELD_MAX : MAX_FRAME;
    localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(LEN_LIMIT_I);

    // CRC-16/ARC, reflected form
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // register indexes on the config port
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_START       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PLAIN_START = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_END         = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ESCAPE      = 2'd3;

    // code reset values
    localparam logic [7:0] START_CODE_RST       = 8'hFD;
    localparam logic [7:0] PLAIN_START_CODE_RST = 8'hFE;
    localparam logic [7:0] END_CODE_RST         = 8'hEF;
    localparam logic [7:0] ESCAPE_CODE_RST      = 8'hEA;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_DATA   = 3'd1,
        PH_ESC    = 3'd2,
        PH_CRC_HI = 3'd3,
        PH_CRC_LO = 3'd4
    } t_phase;

    typedef struct packed {
        logic [7:0] start_code;
        logic [7:0] plain_start_code;
        logic [7:0] end_code;
        logic [7:0] escape_code;
    } t_cfg;

    typedef struct packed {
        logic             emit;
        logic [7:0]       payload_byte;
        logic             frame_end;
        logic             crc_ok;
        logic [LEN_W-1:0] frame_length;
        logic             length_overflow;
    } t_result;

endpackage

[rtl/core/ecfr_cfg.sv]
// Code register file of the frame receiver: four 8-bit codes, write only.
// Depends on ecfr_pkg.
module ecfr_cfg
    import ecfr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [7:0]           i_cfg_wdata,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_START:       n_cfg.start_code       = i_cfg_wdata;
                REG_PLAIN_START: n_cfg.plain_start_code = i_cfg_wdata;
                REG_END:         n_cfg.end_code         = i_cfg_wdata;
                REG_ESCAPE:      n_cfg.escape_code      = i_cfg_wdata;
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_code       <= START_CODE_RST;
            r_cfg.plain_start_code <= PLAIN_START_CODE_RST;
            r_cfg.end_code         <= END_CODE_RST;
            r_cfg.escape_code      <= ESCAPE_CODE_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/core/ecfr_crc.sv]
// One-byte CRC-16/ARC update (reflected poly 0xA001), purely combinational.
// Depends on ecfr_pkg.
module ecfr_crc
    import ecfr_pkg::*;
(
    input  logic [15:0] i_crc,
    input  logic [7:0]  i_byte,
    output logic [15:0] o_crc
);

    always_comb begin
        logic [15:0] c;
        c = i_crc ^ {8'h00, i_byte};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        o_crc = c;
    end

endmodule

[rtl/core/ecfr_deframe.sv]
// Deframing state machine: phase, running CRC, payload count and overflow,
// and the result of each processed byte. Depends on ecfr_pkg and ecfr_crc.
module ecfr_deframe
    import ecfr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_advance,
    input  logic [7:0] i_byte,
    input  t_cfg       i_cfg,
    output t_result    o_res
);

    t_phase           r_phase, n_phase;
    logic [15:0]      r_crc, n_crc;
    logic [7:0]       r_crc_hi, n_crc_hi;
    logic [LEN_W-1:0] r_count, n_count;
    logic             r_overflow, n_overflow;
    logic [15:0]      crc_upd;

    ecfr_crc u_crc (
        .i_crc  (r_crc),
        .i_byte (i_byte),
        .o_crc  (crc_upd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_crc      <= '0;
            r_crc_hi   <= '0;
            r_count    <= '0;
            r_overflow <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_crc      <= n_crc;
            r_crc_hi   <= n_crc_hi;
            r_count    <= n_count;
            r_overflow <= n_overflow;
        end
    end

    always_comb begin
        logic keep;
        keep       = 1'b0;
        n_phase    = r_phase;
        n_crc      = r_crc;
        n_crc_hi   = r_crc_hi;
        n_count    = r_count;
        n_overflow = r_overflow;
        o_res      = '0;
        if (i_advance) begin
            unique case (r_phase)
                PH_DATA: begin
                    // end code wins over escape when both are set equal
                    if (i_byte == i_cfg.end_code) begin
                        n_phase = PH_CRC_HI;
                    end else begin
                        n_crc = crc_upd;
                        if (i_byte == i_cfg.escape_code) begin
                            n_phase = PH_ESC;
                        end else begin
                            keep = 1'b1;
                        end
                    end
                end
                PH_ESC: begin
                    n_phase = PH_DATA;
                    if (i_byte == i_cfg.escape_code || i_byte == i_cfg.end_code ||
                        i_byte == i_cfg.plain_start_code) begin
                        n_crc = crc_upd;
                        keep  = 1'b1;
                    end
                end
                PH_CRC_HI: begin
                    n_crc_hi = i_byte;
                    n_phase  = PH_CRC_LO;
                end
                PH_CRC_LO: begin
                    o_res.emit            = 1'b1;
                    o_res.frame_end       = 1'b1;
                    o_res.crc_ok          = ({r_crc_hi, i_byte} == r_crc);
                    o_res.frame_length    = r_count;
                    o_res.length_overflow = r_overflow;
                    n_phase               = PH_IDLE;
                end
                default: begin
                    // idle and unused encodings
                    n_phase = PH_IDLE;
                    if (i_byte == i_cfg.start_code) begin
                        n_crc      = '0;
                        n_count    = '0;
                        n_overflow = 1'b0;
                        n_crc_hi   = '0;
                        n_phase    = PH_DATA;
                    end
                end
            endcase
            if (keep) begin
                o_res.emit         = 1'b1;
                o_res.payload_byte = i_byte;
                if (r_count >= LEN_LIMIT) begin
                    n_overflow = 1'b1;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= LEN_LIMIT)
        else $error("payload count beyond limit");

    a_ovf_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_overflow |-> (r_count == LEN_LIMIT))
        else $error("overflow flag set below the length limit");

    a_report_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && r_phase == PH_CRC_LO) |=> (r_phase == PH_IDLE))
        else $error("end report did not return to idle");

    a_hold_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_advance |=> ($stable(r_phase) && $stable(r_crc) && $stable(r_count)))
        else $error("state changed without a processed byte");
`endif

endmodule

[rtl/core/escaped_crc16_frame_receiver.sv]
// Top level of the escaped CRC-16 frame receiver: input register, code
// registers, deframer and output register. Depends on ecfr_pkg and submodules.
//
// Usage:
//   Slave stream (i_s_axis_*): one received serial byte per request in tdata.
//   Master stream (o_m_axis_*): zero or one result per input byte. A payload
//   byte carries the unescaped byte with frame_end low; the frame's second
//   CRC byte produces an end report with frame_end high, crc_ok, the
//   saturated frame_length and length_overflow. Dropped bytes, codes and the
//   first CRC byte produce nothing.
//   Config port: write i_cfg_wdata to code register i_cfg_addr when i_cfg_we
//   is high (0 start, 1 plain start, 2 end, 3 escape); only while idle.
// Path: an accepted byte is held in the input register, processed when it
//   moves on, and its result is presented from the output register.
// Throughput: one byte per cycle while the output register is not stalled,
//   limited by the combinational CRC and phase logic between the registers.
// Stall: when the output register holds an untaken result, the input register
//   holds its byte and o_s_axis_tready drops until the result is taken.
// Reset (i_rst_n low, synchronous): both registers empty, phase waiting for a
//   start code, CRC, count and overflow cleared, codes back to 0xFD, 0xFE,
//   0xEF and 0xEA.
module escaped_crc16_frame_receiver
    import ecfr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // slave stream
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [7:0]           i_s_axis_tdata,   // [7:0] rx_byte
    // master stream
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [23:0]          o_m_axis_tdata,   // [7:0] payload_byte, [18:8] frame_length
    output logic [2:0]           o_m_axis_tuser,   // [0] frame_end, [1] crc_ok,
                                                   // [2] length_overflow
    // code register writes
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [7:0]           i_cfg_wdata
);

    t_cfg       cfg;
    t_result    res;
    logic       advance;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;

    // byte in the input register moves on when the output register is empty or being taken
    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;

    ecfr_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    ecfr_deframe u_deframe (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_byte    (r_in_byte),
        .i_cfg     (cfg),
        .o_res     (res)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && res.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res.emit) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'b0, r_out.frame_length, r_out.payload_byte};
    assign o_m_axis_tuser  = {r_out.length_overflow, r_out.crc_ok, r_out.frame_end};

endmodule

[tb/tb_top.sv]
// Testbench for escaped_crc16_frame_receiver: stuffed frames, code register
// writes and random stream traffic, checked against an in-bench deframer model.
// Depends on ecfr_pkg and the receiver RTL.
module tb_top;
    import ecfr_pkg::*;

    typedef struct packed {
        logic [7:0]       payload;
        logic             frame_end;
        logic             crc_ok;
        logic [LEN_W-1:0] length;
        logic             overflow;
    } t_rx_out;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [7:0]           i_s_axis_tdata = 8'h00;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic [23:0]          o_m_axis_tdata;   // [7:0] payload_byte, [18:8] frame_length
    logic [2:0]           o_m_axis_tuser;   // [0] frame_end, [1] crc_ok, [2] length_overflow
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_addr = '0;
    logic [7:0]           i_cfg_wdata = 8'h00;

    // deframer model state
    logic [7:0]       start_c = START_CODE_RST;
    logic [7:0]       plain_c = PLAIN_START_CODE_RST;
    logic [7:0]       end_c   = END_CODE_RST;
    logic [7:0]       esc_c   = ESCAPE_CODE_RST;
    t_phase           rx_phase = PH_IDLE;
    logic [15:0]      crc_acc = 16'h0000;
    logic [7:0]       crc_hi = 8'h00;
    logic [LEN_W-1:0] pay_count = '0;
    logic             pay_ovf = 1'b0;

    t_rx_out rx_expected_q[$];
    int      mismatch_count = 0;
    int      frame_bytes_sent = 0;  // bytes the receiver acts on (idle noise excluded)
    bit      steady_flow = 1'b0;    // no gaps on either side while set

    escaped_crc16_frame_receiver uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always #1 i_clk = ~i_clk;

    // CRC-16/ARC, one byte, LSB first
    function automatic logic [15:0] crc16_arc(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        return r;
    endfunction

    // append one expected result at the tail
    task automatic queue_expected(input t_rx_out r);
        rx_expected_q = {rx_expected_q, r};
    endtask

    // Advance the deframer model by one accepted byte, queue what it emits.
    task automatic deframe_byte(input logic [7:0] b);
        t_rx_out r;
        bit      keep;
        r    = '0;
        keep = 1'b0;
        case (rx_phase)
            PH_DATA: begin
                if (b == end_c) begin
                    rx_phase = PH_CRC_HI;
                end else if (b == esc_c) begin
                    crc_acc  = crc16_arc(crc_acc, b);   // escape code is covered too
                    rx_phase = PH_ESC;
                end else begin
                    keep = 1'b1;
                end
            end
            PH_ESC: begin
                rx_phase = PH_DATA;
                // only these literals survive; anything else is dropped silently
                keep = (b == esc_c) || (b == end_c) || (b == plain_c);
            end
            PH_CRC_HI: begin
                crc_hi   = b;
                rx_phase = PH_CRC_LO;
            end
            PH_CRC_LO: begin
                r.frame_end = 1'b1;
                r.crc_ok    = ({crc_hi, b} == crc_acc);
                r.length    = pay_count;
                r.overflow  = pay_ovf;
                queue_expected(r);
                rx_phase = PH_IDLE;
            end
            default: begin
                rx_phase = PH_IDLE;
                if (b == start_c) begin
                    crc_acc   = 16'h0000;
                    crc_hi    = 8'h00;
                    pay_count = '0;
                    pay_ovf   = 1'b0;
                    rx_phase  = PH_DATA;
                end
            end
        endcase
        if (keep) begin
            crc_acc = crc16_arc(crc_acc, b);
            // count saturates at the limit; a byte past it only flags overflow
            if (pay_count >= LEN_LIMIT)
                pay_ovf = 1'b1;
            else
                pay_count = pay_count + 1'b1;
            r.payload = b;
            queue_expected(r);
        end
    endtask

    // Master side: random backpressure, off during steady stretches.
    always @(negedge i_clk) begin
        i_m_axis_tready <= steady_flow || ($urandom_range(99) >= 8);
    end

    // Result checker: every taken result against the oldest expectation.
    always @(posedge i_clk) begin
        t_rx_out got;
        t_rx_out exp_r;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.payload   = o_m_axis_tdata[7:0];
            got.length    = o_m_axis_tdata[18:8];
            got.frame_end = o_m_axis_tuser[0];
            got.crc_ok    = o_m_axis_tuser[1];
            got.overflow  = o_m_axis_tuser[2];
            if (rx_expected_q.size() == 0) begin
                mismatch_count++;
                $display("%0t unexpected result: payload=%h end=%b crc_ok=%b len=%0d ovf=%b",
                         $time, got.payload, got.frame_end, got.crc_ok, got.length,
                         got.overflow);
            end else begin
                exp_r = rx_expected_q.pop_front();
                if (got !== exp_r) begin
                    mismatch_count++;
                    $display("%0t mismatch exp: payload=%h end=%b crc_ok=%b len=%0d ovf=%b",
                             $time, exp_r.payload, exp_r.frame_end, exp_r.crc_ok,
                             exp_r.length, exp_r.overflow);
                    $display("%0t          got: payload=%h end=%b crc_ok=%b len=%0d ovf=%b",
                             $time, got.payload, got.frame_end, got.crc_ok, got.length,
                             got.overflow);
                end
            end
        end
    end

    // One byte request on the slave side. Entered and left just after a
    // falling edge; tvalid stays high afterwards so back-to-back requests
    // need no second assignment in the same step.
    task automatic send_byte(input logic [7:0] b);
        while (!steady_flow && $urandom_range(99) < 8) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        do @(posedge i_clk); while (!o_s_axis_tready);
        if (rx_phase != PH_IDLE || b == start_c)
            frame_bytes_sent++;
        deframe_byte(b);
        @(negedge i_clk);
    endtask

    // Drop tvalid and wait until every expected result has been taken,
    // then let a byte that emits nothing leave the pipe.
    task automatic wait_idle();
        i_s_axis_tvalid <= 1'b0;
        for (int k = 0; k < 20000 && rx_expected_q.size() != 0; k++)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_code(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        case (idx)
            REG_START:       start_c = val;
            REG_PLAIN_START: plain_c = val;
            REG_END:         end_c   = val;
            REG_ESCAPE:      esc_c   = val;
            default: ;
        endcase
    endtask

    task automatic set_codes(input logic [7:0] s, input logic [7:0] p,
                             input logic [7:0] e, input logic [7:0] x);
        wait_idle();
        write_code(REG_START, s);
        write_code(REG_PLAIN_START, p);
        write_code(REG_END, e);
        write_code(REG_ESCAPE, x);
    endtask

    // payload byte biased toward the current codes
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(12))
            0:       return start_c;
            1:       return plain_c;
            2:       return end_c;
            3:       return esc_c;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Push the model back to waiting for a start code, whatever the codes are.
    task automatic close_frame();
        while (rx_phase != PH_IDLE)
            send_byte(rx_phase == PH_DATA ? end_c : 8'($urandom_range(255)));
    endtask

    task automatic send_noise(input int n);
        repeat (n) send_byte(pick_byte());
        close_frame();
    endtask

    // Stuffed frame with n kept payload bytes, CRC taken from the model so a
    // good frame stays good under any code setting; bad flips one CRC bit.
    task automatic send_frame(input int n, input bit bad, input bit with_drops);
        logic [7:0]  b;
        logic [7:0]  d;
        logic [15:0] c;
        send_byte(start_c);
        for (int i = 0; i < n; i++) begin
            b = pick_byte();
            if (b == end_c || b == esc_c || (b == plain_c && $urandom_range(1)))
                send_byte(esc_c);
            send_byte(b);
            if (with_drops && $urandom_range(11) == 0) begin
                do d = 8'($urandom_range(255)); while (d == esc_c || d == end_c || d == plain_c);
                send_byte(esc_c);
                send_byte(d);
            end
        end
        send_byte(end_c);
        c = crc_acc ^ (bad ? (16'd1 << $urandom_range(15)) : 16'd0);
        send_byte(c[15:8]);
        send_byte(c[7:0]);
        close_frame();
    endtask

    // Standard check string "123456789" has CRC-16/ARC 0xBB3D.
    task automatic test_known_check();
        send_byte(8'h5A);                 // ignored while waiting for start
        send_byte(start_c);
        for (int i = 0; i < 9; i++)
            send_byte(8'h31 + 8'(i));
        send_byte(end_c);
        send_byte(8'hBB);
        send_byte(8'h3D);
    endtask

    task automatic test_empty_frame();
        send_byte(start_c);
        send_byte(end_c);
        send_byte(8'h00);
        send_byte(8'h00);
    endtask

    // Field extremes, start code as payload, each kept literal, a dropped
    // literal, then a corrupted CRC.
    task automatic test_escapes();
        send_byte(start_c);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(start_c);
        send_byte(esc_c);
        send_byte(end_c);
        send_byte(esc_c);
        send_byte(esc_c);
        send_byte(esc_c);
        send_byte(plain_c);
        send_byte(esc_c);
        send_byte(8'h55);
        send_byte(end_c);
        send_byte(crc_acc[15:8]);
        send_byte(crc_acc[7:0] ^ 8'h01);
    endtask

    // One frame running a byte past the length limit, with no gaps on either
    // side. Payload stays below 0x80, clear of the reset codes.
    task automatic test_overflow();
        steady_flow = 1'b1;
        send_byte(start_c);
        for (int i = 0; i <= int'(LEN_LIMIT); i++)
            send_byte(8'(i) & 8'h7F);
        send_byte(end_c);
        send_byte(crc_acc[15:8]);
        send_byte(crc_acc[7:0]);
        wait_idle();
        steady_flow = 1'b0;
    endtask

    // Extreme and colliding code settings.
    task automatic test_code_writes();
        set_codes(8'h00, 8'h00, 8'h00, 8'h00);
        send_noise(10);
        set_codes(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_noise(10);
        set_codes(8'h7E, 8'h7D, 8'h7F, 8'h7F);   // end equals escape
        repeat (2) send_frame($urandom_range(6), 1'b0, 1'b1);
        set_codes(8'hC0, 8'hC0, 8'h10, 8'h20);   // start equals plain start
        repeat (2) send_frame($urandom_range(6), 1'b0, 1'b1);
        set_codes(8'h30, 8'h31, 8'h30, 8'h32);   // start equals end
        repeat (2) send_frame($urandom_range(6), 1'b0, 1'b1);
        set_codes(START_CODE_RST, PLAIN_START_CODE_RST, END_CODE_RST, ESCAPE_CODE_RST);
    endtask

    // Mostly well-formed frames with random content, some noise and bad CRCs;
    // on longer runs the code settings change every couple of hundred bytes.
    task automatic test_random_traffic(input int n_bytes);
        int         stop_at;
        int         next_cfg;
        logic [7:0] s;
        logic [7:0] p;
        logic [7:0] e;
        logic [7:0] x;
        stop_at  = frame_bytes_sent + n_bytes;
        next_cfg = frame_bytes_sent + 220;
        while (frame_bytes_sent < stop_at) begin
            if (frame_bytes_sent >= next_cfg) begin
                next_cfg = frame_bytes_sent + 220;
                case ($urandom_range(3))
                    0: begin
                        s = START_CODE_RST;
                        p = PLAIN_START_CODE_RST;
                        e = END_CODE_RST;
                        x = ESCAPE_CODE_RST;
                    end
                    3: begin
                        s = 8'($urandom_range(255));
                        p = 8'($urandom_range(255));
                        e = 8'($urandom_range(255));
                        x = 8'($urandom_range(255));
                    end
                    default: begin
                        do begin
                            s = 8'($urandom_range(255));
                            p = 8'($urandom_range(255));
                            e = 8'($urandom_range(255));
                            x = 8'($urandom_range(255));
                        end while (s == p || s == e || s == x || p == e || p == x || e == x);
                    end
                endcase
                set_codes(s, p, e, x);
            end
            if ($urandom_range(99) < 10)
                send_noise($urandom_range(1, 4));
            else if ($urandom_range(9) == 0)
                send_frame($urandom_range(25, 80), $urandom_range(3) == 0, 1'b1);
            else
                send_frame($urandom_range(24), $urandom_range(3) == 0, 1'b1);
        end
    endtask

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_known_check();
        test_empty_frame();
        test_escapes();
        test_overflow();
        test_code_writes();
        test_random_traffic(24);

        wait_idle();
        if (rx_expected_q.size() != 0) begin
            mismatch_count++;
            $display("%0t %0d expected results never arrived", $time, rx_expected_q.size());
        end
        if (mismatch_count == 0)
            $display("PASS escaped_crc16_frame_receiver");
        else
            $display("FAIL escaped_crc16_frame_receiver");
        $finish;
    end

    // run limit, far beyond the slowest correct run
    initial begin
        #2000000;
        $display("%0t run limit reached", $time);
        $display("FAIL escaped_crc16_frame_receiver");
        $finish;
    end

endmodule

[sim.f]
rtl/core/ecfr_pkg.sv
rtl/core/ecfr_cfg.sv
rtl/core/ecfr_crc.sv
rtl/core/ecfr_deframe.sv
rtl/core/escaped_crc16_frame_receiver.sv
tb/tb_top.sv
